// ===== rtl/tshc_pkg.sv =====
// shared types and constants for the tour swap hill climb engine
package tshc_pkg;

    localparam int NUM_CITIES = 64;
    localparam int CITY_BITS  = $clog2(NUM_CITIES);
    localparam int DIST_BITS  = 24;
    localparam int LEN_BITS   = 30;
    localparam int DADDR_BITS = 2 * CITY_BITS;

    localparam logic [LEN_BITS-1:0] LENGTH_MAX = 30'd1073741760;
    localparam logic [CITY_BITS-1:0] LAST_POS  = CITY_BITS'(NUM_CITIES - 1);

    localparam logic [2:0] ACT_WRITE_DIST = 3'd0;
    localparam logic [2:0] ACT_WRITE_TOUR = 3'd1;
    localparam logic [2:0] ACT_EVALUATE   = 3'd2;
    localparam logic [2:0] ACT_TRY_SWAP   = 3'd3;
    localparam logic [2:0] ACT_READ_POS   = 3'd4;

    typedef logic [CITY_BITS-1:0] city_t;
    typedef logic [DIST_BITS-1:0] dist_t;
    typedef logic [LEN_BITS-1:0]  len_t;

    typedef struct packed {
        logic  start;
        logic  swap_en;
        city_t pos_a;
        city_t pos_b;
    } walk_ctrl_t;

    typedef struct packed {
        logic  done;
        len_t  length;
        city_t city_a;
        city_t city_b;
    } walk_stat_t;

endpackage

// ===== rtl/tshc_ram.sv =====
// generic single write, single read ram with registered read data
module tshc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tshc_walk.sv =====
// tour walk: streams tour positions and edge distances, sums the closed length
module tshc_walk (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tshc_pkg::walk_ctrl_t              ctrl,
    output tshc_pkg::city_t                   tour_raddr,
    input  tshc_pkg::city_t                   tour_rdata,
    output logic [tshc_pkg::DADDR_BITS-1:0]   dist_raddr,
    input  tshc_pkg::dist_t                   dist_rdata,
    output tshc_pkg::walk_stat_t              stat
);

    logic            issuing_reg, issuing_next;
    tshc_pkg::city_t issue_pos_reg, issue_pos_next;
    logic            tvalid_reg, tvalid_next;
    tshc_pkg::city_t tidx_reg, tidx_next;
    logic            close_reg, close_next;
    logic            dvalid_reg, dvalid_next;
    logic            dlast_reg, dlast_next;
    logic            done_reg, done_next;
    tshc_pkg::city_t first_reg, first_next;
    tshc_pkg::city_t prev_reg, prev_next;
    tshc_pkg::city_t city_a_reg, city_a_next;
    tshc_pkg::city_t city_b_reg, city_b_next;
    tshc_pkg::len_t  sum_reg, sum_next;
    logic [tshc_pkg::LEN_BITS:0] sum_wide;

    // positions a and b read each other's city, so the swap is never written early
    always_comb
    begin
        tour_raddr = issue_pos_reg;
        if (ctrl.swap_en && issue_pos_reg == ctrl.pos_a)
        begin
            tour_raddr = ctrl.pos_b;
        end
        else if (ctrl.swap_en && issue_pos_reg == ctrl.pos_b)
        begin
            tour_raddr = ctrl.pos_a;
        end
    end

    assign dist_raddr = close_reg ? {prev_reg, first_reg} : {prev_reg, tour_rdata};

    assign sum_wide = {1'b0, sum_reg}
                    + (tshc_pkg::LEN_BITS + 1)'(dist_rdata);

    always_comb
    begin
        issuing_next   = issuing_reg;
        issue_pos_next = issue_pos_reg;
        tvalid_next    = 1'b0;
        tidx_next      = issue_pos_reg;
        close_next     = 1'b0;
        dvalid_next    = 1'b0;
        dlast_next     = 1'b0;
        done_next      = 1'b0;
        first_next     = first_reg;
        prev_next      = prev_reg;
        city_a_next    = city_a_reg;
        city_b_next    = city_b_reg;
        sum_next       = sum_reg;

        if (ctrl.start)
        begin
            issuing_next   = 1'b1;
            issue_pos_next = '0;
            sum_next       = '0;
        end
        else if (issuing_reg)
        begin
            tvalid_next    = 1'b1;
            issue_pos_next = issue_pos_reg + 1'b1;
            if (issue_pos_reg == tshc_pkg::LAST_POS)
            begin
                issuing_next = 1'b0;
            end
        end

        if (tvalid_reg)
        begin
            prev_next = tour_rdata;
            if (tidx_reg == '0)
            begin
                first_next = tour_rdata;
            end
            else
            begin
                dvalid_next = 1'b1;
            end
            if (tidx_reg == ctrl.pos_a)
            begin
                city_a_next = tour_rdata;
            end
            if (tidx_reg == ctrl.pos_b)
            begin
                city_b_next = tour_rdata;
            end
            if (tidx_reg == tshc_pkg::LAST_POS)
            begin
                close_next = 1'b1;
            end
        end

        // closing edge from the last city back to the first
        if (close_reg)
        begin
            dvalid_next = 1'b1;
            dlast_next  = 1'b1;
        end

        if (dvalid_reg)
        begin
            if (sum_wide > {1'b0, tshc_pkg::LENGTH_MAX})
            begin
                sum_next = tshc_pkg::LENGTH_MAX;
            end
            else
            begin
                sum_next = sum_wide[tshc_pkg::LEN_BITS-1:0];
            end
            done_next = dlast_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg <= 1'b0;
            tvalid_reg  <= 1'b0;
            close_reg   <= 1'b0;
            dvalid_reg  <= 1'b0;
            dlast_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            issuing_reg <= issuing_next;
            tvalid_reg  <= tvalid_next;
            close_reg   <= close_next;
            dvalid_reg  <= dvalid_next;
            dlast_reg   <= dlast_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_pos_reg <= issue_pos_next;
        tidx_reg      <= tidx_next;
        first_reg     <= first_next;
        prev_reg      <= prev_next;
        city_a_reg    <= city_a_next;
        city_b_reg    <= city_b_next;
        sum_reg       <= sum_next;
    end

    assign stat.done   = done_reg;
    assign stat.length = sum_reg;
    assign stat.city_a = city_a_reg;
    assign stat.city_b = city_b_reg;

endmodule

// ===== rtl/tour_swap_hill_climb.sv =====
// top level of the tour swap hill climb engine
//
// input channel: in_valid / in_stall carry one item (action, index_a, index_b,
// dist_value); output channel: out_valid / out_stall carry one result item
// (accepted, tour_length, city_id) for every input item, in order.
// the distance matrix and the tour live in two rams with registered read
// data; both are undefined after reset until written, while the kept length
// resets to zero. one item is worked on at a time: in_stall is high from
// accept until the result reaches the output register; evaluate and swap
// walk the tour, one tour ram read and one distance ram read per edge; a kept
// swap then writes both swapped cities back into the tour ram in ST_WB_A and
// ST_WB_B. the output register frees the engine: the next item is taken while
// a result still waits under out_stall; a second finished result waits in
// the engine until the first is taken, and in_stall stays high meanwhile.
// reset is asynchronous and active low and clears the kept length and all
// handshake state.
module tour_swap_hill_climb (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    action,
    input  logic [5:0]                    index_a,
    input  logic [5:0]                    index_b,
    input  logic [23:0]                   dist_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          accepted,
    output logic [29:0]                   tour_length,
    output logic [5:0]                    city_id
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WALK = 3'd1;
    localparam logic [2:0] ST_WB_A = 3'd2;
    localparam logic [2:0] ST_WB_B = 3'd3;
    localparam logic [2:0] ST_READ = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic                 swap_reg, swap_next;
    tshc_pkg::city_t      a_reg, a_next;
    tshc_pkg::city_t      b_reg, b_next;
    tshc_pkg::len_t       kept_reg, kept_next;
    logic                 res_acc_reg, res_acc_next;
    tshc_pkg::city_t      res_city_reg, res_city_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_acc_reg;
    tshc_pkg::len_t       out_len_reg;
    tshc_pkg::city_t      out_city_reg;
    logic                 out_load;

    tshc_pkg::walk_ctrl_t walk_ctrl;
    tshc_pkg::walk_stat_t walk_stat;

    logic                 tour_we;
    tshc_pkg::city_t      tour_waddr, tour_wdata, tour_raddr, tour_rdata;
    tshc_pkg::city_t      walk_tour_raddr;
    logic                 dist_we;
    logic [tshc_pkg::DADDR_BITS-1:0] dist_waddr, dist_raddr;
    tshc_pkg::dist_t      dist_rdata;
    logic                 in_take;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign walk_ctrl.start   = in_take && (action inside {tshc_pkg::ACT_EVALUATE,
                                                          tshc_pkg::ACT_TRY_SWAP});
    assign walk_ctrl.swap_en = swap_reg;
    assign walk_ctrl.pos_a   = a_reg;
    assign walk_ctrl.pos_b   = b_reg;

    assign dist_we    = in_take && (action == tshc_pkg::ACT_WRITE_DIST);
    assign dist_waddr = {index_a, index_b};
    assign tour_raddr = (state_reg == ST_IDLE) ? index_a : walk_tour_raddr;

    always_comb
    begin
        tour_we    = 1'b0;
        tour_waddr = index_a;
        tour_wdata = index_b;
        if (in_take && action == tshc_pkg::ACT_WRITE_TOUR)
        begin
            tour_we = 1'b1;
        end
        else if (state_reg == ST_WB_A)
        begin
            tour_we    = 1'b1;
            tour_waddr = a_reg;
            tour_wdata = walk_stat.city_a;
        end
        else if (state_reg == ST_WB_B)
        begin
            tour_we    = 1'b1;
            tour_waddr = b_reg;
            tour_wdata = walk_stat.city_b;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        swap_next      = swap_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        kept_next      = kept_reg;
        res_acc_next   = res_acc_reg;
        res_city_next  = res_city_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    a_next        = index_a;
                    b_next        = index_b;
                    swap_next     = (action == tshc_pkg::ACT_TRY_SWAP);
                    res_acc_next  = 1'b0;
                    res_city_next = '0;
                    case (action)
                        tshc_pkg::ACT_EVALUATE,
                        tshc_pkg::ACT_TRY_SWAP: state_next = ST_WALK;
                        tshc_pkg::ACT_READ_POS: state_next = ST_READ;
                        default:                state_next = ST_DONE;
                    endcase
                end
            end
            ST_WALK:
            begin
                if (walk_stat.done)
                begin
                    if (!swap_reg)
                    begin
                        kept_next  = walk_stat.length;
                        state_next = ST_DONE;
                    end
                    else if (walk_stat.length > kept_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        kept_next    = walk_stat.length;
                        res_acc_next = 1'b1;
                        state_next   = ST_WB_A;
                    end
                end
            end
            ST_WB_A:
            begin
                state_next = ST_WB_B;
            end
            ST_WB_B:
            begin
                state_next = ST_DONE;
            end
            ST_READ:
            begin
                res_city_next = tour_rdata;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kept_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kept_reg      <= kept_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        swap_reg     <= swap_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        res_acc_reg  <= res_acc_next;
        res_city_reg <= res_city_next;
        if (out_load)
        begin
            out_acc_reg  <= res_acc_reg;
            out_len_reg  <= kept_reg;
            out_city_reg <= res_city_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign accepted    = out_acc_reg;
    assign tour_length = out_len_reg;
    assign city_id     = out_city_reg;

    tshc_ram #(
        .WIDTH (tshc_pkg::DIST_BITS),
        .DEPTH (tshc_pkg::NUM_CITIES * tshc_pkg::NUM_CITIES)
    ) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (dist_value),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    tshc_ram #(
        .WIDTH (tshc_pkg::CITY_BITS),
        .DEPTH (tshc_pkg::NUM_CITIES)
    ) u_tour_ram (
        .clk   (clk),
        .we    (tour_we),
        .waddr (tour_waddr),
        .wdata (tour_wdata),
        .raddr (tour_raddr),
        .rdata (tour_rdata)
    );

    tshc_walk u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (walk_ctrl),
        .tour_raddr (walk_tour_raddr),
        .tour_rdata (tour_rdata),
        .dist_raddr (dist_raddr),
        .dist_rdata (dist_rdata),
        .stat       (walk_stat)
    );

endmodule
